FILE: rtl/core/rrt_pkg.sv
// Shared types and command codes for the received range tracker.
package rrt_pkg;

    localparam int unsigned CMD_W     = 2;
    localparam int unsigned GAP_CNT_W = 5;
    localparam logic [GAP_CNT_W-1:0] MOST_GAPS = 5'd17;
    localparam logic [GAP_CNT_W-1:0] GAP_SAT   = 5'd31;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_LIST  = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MINIT,
        S_MRD,
        S_MPROC,
        S_MWR2,
        S_MFIN,
        S_GINIT,
        S_GRD,
        S_GPROC,
        S_GEND,
        S_RESP
    } t_state;

endpackage

FILE: rtl/core/received_range_tracker.sv
// Received range tracker: sorted range table in a two-bank RAM with merge and gap walks.
//
// Keeps up to MAX_RANGES disjoint inclusive byte ranges of one asset in a single-port-write,
// registered-read RAM split into two banks. A mark walks the live bank entry by entry, a read
// and a process step each (plus a write step when a new range is slotted in before an entry),
// writing the merged table into the other bank, then swaps banks unless the result would not
// fit, in which case table_full is flagged and nothing changes. Every command then walks the
// table once more, a read and a process step per entry, to count gaps below asset_size; a
// list walks it again emitting gaps. One item is handled at a time; the input is stalled until
// its last result is loaded into the output register.
module received_range_tracker #(
    parameter int MAX_RANGES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [31:0]                i_cfg_asset_size,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [rrt_pkg::CMD_W-1:0]  i_cmd,
    input  logic [31:0]                i_start_offset,
    input  logic [31:0]                i_byte_count,
    input  logic [4:0]                 i_max_gaps,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_exists,
    output logic                       o_complete,
    output logic [4:0]                 o_missing_count,
    output logic                       o_table_full,
    output logic [31:0]                o_gap_start,
    output logic [31:0]                o_gap_length,
    output logic                       o_gap_valid,
    output logic                       o_last
);
    import rrt_pkg::*;

    localparam int AW    = $clog2(MAX_RANGES);
    localparam int CW    = $clog2(MAX_RANGES + 1);
    localparam int DEPTH = 2 * (1 << AW);
    localparam logic [CW-1:0] FULL_N = CW'(MAX_RANGES);

    // bank-split table, first offset in the upper half of each word
    logic [63:0] mem [DEPTH];
    logic [63:0] r_rd;

    t_state r_state, n_state;
    logic              r_bank, n_bank;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_n, n_n;
    logic              r_placed, n_placed;
    logic              r_ovf, n_ovf;
    logic [31:0]       r_s, n_s;
    logic [31:0]       r_e, n_e;
    logic              r_seen, n_seen;
    logic              r_done, n_done;
    logic              r_full, n_full;
    logic [31:0]       r_size;
    t_cmd              r_cmd, n_cmd;
    logic [31:0]       r_start, n_start;
    logic [31:0]       r_bytes, n_bytes;
    logic [4:0]        r_want, n_want;
    logic              r_emode, n_emode;
    logic [32:0]       r_low, n_low;
    logic [4:0]        r_gn, n_gn;
    logic [4:0]        r_miss, n_miss;
    logic [4:0]        r_emit, n_emit;
    logic [4:0]        r_emd, n_emd;

    logic              r_o_valid;
    logic              r_o_exists, r_o_complete;
    logic [4:0]        r_o_miss;
    logic              r_o_full;
    logic [31:0]       r_o_gs, r_o_gl;
    logic              r_o_gv, r_o_last;

    // memory and output-load controls
    logic              rd_en, we, load, ld_gap, ld_last;
    logic [AW:0]       raddr, waddr;
    logic [63:0]       wdata;
    logic [31:0]       ld_gs, ld_gl;

    logic              acc, out_free;
    logic [31:0]       d_f, d_l;
    logic [32:0]       l_inc, e_inc, size33, sum33;
    logic              c_below, c_above, two_wr, idx_last;
    logic              gap_here, tail_gap, emit_last;
    logic [31:0]       hi, gap_len, tail_len;
    logic [4:0]        gn_tail, miss_calc, emit_calc;
    logic              mf_ovf;
    logic [CW-1:0]     mf_n;

    assign acc      = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign d_f = r_rd[63:32];
    assign d_l = r_rd[31:0];

    // merge compares
    assign l_inc    = {1'b0, d_l} + 33'd1;
    assign e_inc    = {1'b0, r_e} + 33'd1;
    assign c_below  = l_inc < {1'b0, r_s};
    assign c_above  = {1'b0, d_f} > e_inc;
    assign two_wr   = !c_below && c_above && !r_placed;
    assign idx_last = (r_idx + CW'(1)) == r_cnt;
    assign sum33    = {1'b0, r_start} + {1'b0, r_bytes} - 33'd1;

    // gap compares
    assign size33   = {1'b0, r_size};
    assign gap_here = (r_low < {1'b0, d_f}) && (r_low < size33);
    assign hi       = ((d_f - 32'd1) < (r_size - 32'd1)) ? (d_f - 32'd1) : (r_size - 32'd1);
    assign gap_len  = hi - r_low[31:0] + 32'd1;
    assign tail_gap = r_low < size33;
    assign tail_len = r_size - r_low[31:0];
    assign emit_last = (r_emd + 5'd1) == r_emit;
    assign gn_tail  = (tail_gap && r_gn != GAP_SAT) ? r_gn + 5'd1 : r_gn;
    assign miss_calc = r_seen ? gn_tail : 5'd0;
    always_comb begin
        emit_calc = miss_calc;
        if (r_want < emit_calc) emit_calc = r_want;
        if (MOST_GAPS < emit_calc) emit_calc = MOST_GAPS;
    end

    assign mf_ovf = r_ovf || (!r_placed && r_n == FULL_N);
    assign mf_n   = r_placed ? r_n : r_n + CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = (t_cmd'(i_cmd) == CMD_MARK && i_byte_count != 32'd0)
                              ? S_MINIT : S_GINIT;
                end
            end
            S_MINIT: n_state = (r_cnt == '0) ? S_MFIN : S_MRD;
            S_MRD:   n_state = S_MPROC;
            S_MPROC: begin
                if (two_wr)        n_state = S_MWR2;
                else if (idx_last) n_state = S_MFIN;
                else               n_state = S_MRD;
            end
            S_MWR2:  n_state = (r_idx == r_cnt) ? S_MFIN : S_MRD;
            S_MFIN:  n_state = S_GINIT;
            S_GINIT: n_state = (r_cnt == '0) ? S_GEND : S_GRD;
            S_GRD:   n_state = S_GPROC;
            S_GPROC: begin
                if (r_emode && gap_here && !out_free)      n_state = S_GPROC;
                else if (r_emode && gap_here && emit_last) n_state = S_IDLE;
                else if (idx_last)                         n_state = S_GEND;
                else                                       n_state = S_GRD;
            end
            S_GEND: begin
                if (r_emode)                                      n_state = out_free ? S_IDLE : S_GEND;
                else if (r_cmd == CMD_LIST && emit_calc != 5'd0) n_state = S_GINIT;
                else                                              n_state = S_RESP;
            end
            S_RESP:  n_state = out_free ? S_IDLE : S_RESP;
            default: n_state = S_IDLE;
        endcase
    end

    // memory access and result loading
    always_comb begin
        rd_en   = 1'b0;
        raddr   = {r_bank, r_idx[AW-1:0]};
        we      = 1'b0;
        waddr   = {~r_bank, r_n[AW-1:0]};
        wdata   = {d_f, d_l};
        load    = 1'b0;
        ld_gap  = 1'b0;
        ld_last = 1'b1;
        ld_gs   = 32'd0;
        ld_gl   = 32'd0;
        case (r_state)
            S_MRD, S_GRD: rd_en = 1'b1;
            S_MPROC: begin
                if (c_below) begin
                    we = (r_n != FULL_N);
                end else if (c_above) begin
                    we = (r_n != FULL_N);
                    if (!r_placed) wdata = {r_s, r_e};
                end
            end
            S_MWR2:  we = (r_n != FULL_N);
            S_MFIN: begin
                we    = !r_placed && (r_n != FULL_N);
                wdata = {r_s, r_e};
            end
            S_GPROC: begin
                if (r_emode && gap_here && out_free) begin
                    load    = 1'b1;
                    ld_gap  = 1'b1;
                    ld_last = emit_last;
                    ld_gs   = r_low[31:0];
                    ld_gl   = gap_len;
                end
            end
            S_GEND: begin
                if (r_emode && out_free) begin
                    load   = 1'b1;
                    ld_gap = 1'b1;
                    ld_gs  = r_low[31:0];
                    ld_gl  = tail_len;
                end
            end
            S_RESP:  load = out_free;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_bank   = r_bank;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_n      = r_n;
        n_placed = r_placed;
        n_ovf    = r_ovf;
        n_s      = r_s;
        n_e      = r_e;
        n_seen   = r_seen;
        n_done   = r_done;
        n_full   = r_full;
        n_cmd    = r_cmd;
        n_start  = r_start;
        n_bytes  = r_bytes;
        n_want   = r_want;
        n_emode  = r_emode;
        n_low    = r_low;
        n_gn     = r_gn;
        n_miss   = r_miss;
        n_emit   = r_emit;
        n_emd    = r_emd;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_start = i_start_offset;
                    n_bytes = i_byte_count;
                    n_want  = i_max_gaps;
                    n_emode = 1'b0;
                    n_full  = 1'b0;
                end
            end
            S_MINIT: begin
                n_s      = r_start;
                n_e      = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                n_idx    = '0;
                n_n      = '0;
                n_placed = 1'b0;
                n_ovf    = 1'b0;
            end
            S_MPROC: begin
                n_idx = r_idx + CW'(1);
                if (c_below || c_above) begin
                    if (r_n == FULL_N) n_ovf = 1'b1;
                    else               n_n   = r_n + CW'(1);
                    if (c_above) n_placed = 1'b1;
                end else begin
                    if (d_f < r_s) n_s = d_f;
                    if (d_l > r_e) n_e = d_l;
                end
            end
            S_MWR2: begin
                if (r_n == FULL_N) n_ovf = 1'b1;
                else               n_n   = r_n + CW'(1);
            end
            S_MFIN: begin
                if (mf_ovf) begin
                    n_full = 1'b1;
                end else begin
                    n_bank = ~r_bank;
                    n_cnt  = mf_n;
                    n_seen = 1'b1;
                    if (mf_n == CW'(1) && r_s == 32'd0 && e_inc >= size33) n_done = 1'b1;
                end
            end
            S_GINIT: begin
                n_idx = '0;
                n_low = '0;
                n_gn  = '0;
                n_emd = '0;
            end
            S_GPROC: begin
                if (!(r_emode && gap_here && !out_free)) begin
                    n_idx = r_idx + CW'(1);
                    n_low = l_inc;
                    if (gap_here) begin
                        if (r_gn != GAP_SAT) n_gn = r_gn + 5'd1;
                        n_emd = r_emd + 5'd1;
                    end
                end
            end
            S_GEND: begin
                if (!r_emode) begin
                    n_miss  = miss_calc;
                    n_emit  = emit_calc;
                    n_emode = (r_cmd == CMD_LIST) && (emit_calc != 5'd0);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_cnt   <= '0;
            r_seen  <= 1'b0;
            r_done  <= 1'b0;
            r_size  <= 32'd1;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) r_size <= i_cfg_asset_size;
            if (load)          r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_n      <= n_n;
        r_placed <= n_placed;
        r_ovf    <= n_ovf;
        r_s      <= n_s;
        r_e      <= n_e;
        r_full   <= n_full;
        r_cmd    <= n_cmd;
        r_start  <= n_start;
        r_bytes  <= n_bytes;
        r_want   <= n_want;
        r_emode  <= n_emode;
        r_low    <= n_low;
        r_gn     <= n_gn;
        r_miss   <= n_miss;
        r_emit   <= n_emit;
        r_emd    <= n_emd;
        if (load) begin
            r_o_exists   <= r_seen;
            r_o_complete <= r_done;
            r_o_miss     <= r_miss;
            r_o_full     <= ld_gap ? 1'b0 : r_full;
            r_o_gs       <= ld_gs;
            r_o_gl       <= ld_gl;
            r_o_gv       <= ld_gap;
            r_o_last     <= ld_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) r_rd <= mem[raddr];
    end

    // status is captured with the result, so a stalled transaction holds still
    assign o_valid         = r_o_valid;
    assign o_exists        = r_o_exists;
    assign o_complete      = r_o_complete;
    assign o_missing_count = r_o_miss;
    assign o_table_full    = r_o_full;
    assign o_gap_start     = r_o_gs;
    assign o_gap_length    = r_o_gl;
    assign o_gap_valid     = r_o_gv;
    assign o_last          = r_o_last;

endmodule
